// ----- rtl/lpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the lookahead PD path tracker.
// Used by every rtl module; depends on nothing.
package lpt_pkg;

    localparam int PATH_DEPTH = 256;
    localparam int LEN_W      = $clog2(PATH_DEPTH + 1);
    localparam int IDX_W      = $clog2(PATH_DEPTH);

    localparam int DIV_NUM_W  = 63;
    localparam int DIV_DEN_W  = 34;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] ST_ACCEPT    = 3'd0;
    localparam logic [2:0] ST_COMMAND   = 3'd1;
    localparam logic [2:0] ST_NO_PATH   = 3'd2;
    localparam logic [2:0] ST_GOAL      = 3'd3;
    localparam logic [2:0] ST_ZERO_TIME = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [2:0] CFG_KP   = 3'd0;
    localparam logic [2:0] CFG_KD   = 3'd1;
    localparam logic [2:0] CFG_LOOK = 3'd2;
    localparam logic [2:0] CFG_LIN  = 3'd3;
    localparam logic [2:0] CFG_ANG  = 3'd4;

    localparam logic [15:0] KP_RESET   = 16'd512;
    localparam logic [15:0] KD_RESET   = 16'd26;
    localparam logic [30:0] LOOK_RESET = 31'd13107;
    localparam logic [30:0] LIN_RESET  = 31'd19661;
    localparam logic [30:0] ANG_RESET  = 31'd65536;

    localparam logic [63:0] GOAL_TOL2  = 64'd42954916;
    localparam logic [33:0] KD_SCALE   = 34'd15625;

    typedef struct packed {
        logic        [1:0]  operation;
        logic signed [31:0] waypoint_x;
        logic signed [31:0] waypoint_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] heading_cos;
        logic signed [15:0] heading_sin;
        logic        [19:0] elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic        [7:0]  target_index;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } t_out_word;

    typedef enum logic [4:0] {
        DC_IDLE, DC_LOAD, DC_DECODE, DC_LOOK, DC_LSAVE, DC_READ, DC_SQX, DC_SQY,
        DC_WALK, DC_GSQX, DC_GSQY, DC_GCHK, DC_FWD1, DC_FWD2, DC_FWD3, DC_LAT1,
        DC_LAT2, DC_LAT3, DC_PF, DC_PL, DC_KD, DC_KDS, DC_DF, DC_DFGO, DC_DFGET,
        DC_DL, DC_DLGO, DC_DLGET, DC_SUM, DC_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       len_zero;
        logic       far;
        logic       idx_zero;
        logic       stop;
        logic       div_done;
    } t_dp_sts;

endpackage

// ----- rtl/lpt_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lpt_pkg.
module lpt_div import lpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   w_sh;
    logic [DIV_DEN_W:0]   w_sub;
    logic                 w_ge;

    assign w_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_sub = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= i_den;
            r_quo  <= i_num;
        end else if (r_busy) begin
            r_rem <= w_sub[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/lpt_dp.sv -----
`timescale 1ns / 1ps
// Datapath: path memory, configuration, shared multiplier, error and PD arithmetic.
// Depends on lpt_pkg and lpt_div.
module lpt_dp import lpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_word  i_in_word,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    logic [15:0] r_kp;
    logic [15:0] r_kd;
    logic [30:0] r_look;
    logic [30:0] r_lin_lim;
    logic [30:0] r_ang_lim;

    logic [LEN_W-1:0]   r_len;
    logic signed [31:0] r_prev_fwd;
    logic signed [31:0] r_prev_lat;
    logic [31:0]        r_tsc;

    logic [63:0]        r_mem [PATH_DEPTH];
    logic signed [31:0] r_rd_x;
    logic signed [31:0] r_rd_y;

    t_in_word           r_in;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_tgt;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic [63:0]        r_look2;
    logic [63:0]        r_sq;
    logic signed [67:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_fwd;
    logic signed [31:0] r_lat;
    logic signed [40:0] r_pf;
    logic signed [40:0] r_pl;
    logic [29:0]        r_kd15;
    logic               r_dsign;
    logic signed [63:0] r_df;
    logic signed [63:0] r_dl;
    t_out_word          r_res;
    t_out_word          r_out;

    logic signed [32:0] w_dxr, w_dyr, w_dxt, w_dyt, w_dfe, w_dle;
    logic signed [33:0] w_mul_a, w_mul_b;
    logic signed [67:0] w_prod;
    logic [64:0]        w_dsum;
    logic [63:0]        w_dist;
    logic               w_far, w_goal, w_t_zero, w_full, w_last;
    logic [32:0]        w_tsum;
    logic [63:0]        w_dmag;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_DEN_W-1:0] w_den;
    logic [DIV_NUM_W-1:0] w_quo;
    logic               w_div_done, w_div_start;
    logic signed [50:0] w_fsum, w_lsum;
    logic signed [64:0] w_vlin, w_vang;
    logic [2:0]         w_dec_status;

    function automatic logic signed [31:0] f_rnd14(input logic signed [50:0] v);
        logic [50:0]        mag;
        logic [50:0]        q;
        logic signed [51:0] sq;
        mag = v[50] ? 51'(-v) : 51'(v);
        q   = (mag + 51'd8192) >> 14;
        sq  = v[50] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sq > 52'sd2147483647) return 32'sh7fffffff;
        if (sq < -52'sd2147483648) return 32'sh80000000;
        return sq[31:0];
    endfunction

    function automatic logic signed [40:0] f_rnd8(input logic signed [48:0] v);
        logic [48:0] mag;
        logic [48:0] q;
        logic signed [49:0] sq;
        mag = v[48] ? 49'(-v) : 49'(v);
        q   = (mag + 49'd128) >> 8;
        sq  = v[48] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sq[40:0];
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [64:0] v,
                                                   input logic [30:0] lim);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = $signed({34'b0, lim});
        lo = -hi;
        if (v > hi) return hi[31:0];
        if (v < lo) return lo[31:0];
        return v[31:0];
    endfunction

    assign w_dxr = 33'(r_rd_x) - 33'(r_in.robot_x);
    assign w_dyr = 33'(r_rd_y) - 33'(r_in.robot_y);
    assign w_dxt = 33'(r_tx) - 33'(r_in.robot_x);
    assign w_dyt = 33'(r_ty) - 33'(r_in.robot_y);
    assign w_dfe = 33'(r_fwd) - 33'(r_prev_fwd);
    assign w_dle = 33'(r_lat) - 33'(r_prev_lat);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            DC_LOOK: begin
                w_mul_a = $signed(34'(r_look));
                w_mul_b = $signed(34'(r_look));
            end
            DC_SQX: begin
                w_mul_a = 34'(w_dxr);
                w_mul_b = 34'(w_dxr);
            end
            DC_SQY: begin
                w_mul_a = 34'(w_dyr);
                w_mul_b = 34'(w_dyr);
            end
            DC_GSQX: begin
                w_mul_a = 34'(w_dxt);
                w_mul_b = 34'(w_dxt);
            end
            DC_GSQY: begin
                w_mul_a = 34'(w_dyt);
                w_mul_b = 34'(w_dyt);
            end
            DC_FWD1: begin
                w_mul_a = 34'(r_in.heading_cos);
                w_mul_b = 34'(w_dxt);
            end
            DC_FWD2: begin
                w_mul_a = 34'(r_in.heading_sin);
                w_mul_b = 34'(w_dyt);
            end
            DC_LAT1: begin
                w_mul_a = 34'(r_in.heading_cos);
                w_mul_b = 34'(w_dyt);
            end
            DC_LAT2: begin
                w_mul_a = 34'(r_in.heading_sin);
                w_mul_b = 34'(w_dxt);
            end
            DC_PF: begin
                w_mul_a = $signed(34'(r_kp));
                w_mul_b = 34'(r_fwd);
            end
            DC_PL: begin
                w_mul_a = $signed(34'(r_kp));
                w_mul_b = 34'(r_lat);
            end
            DC_KD: begin
                w_mul_a = $signed(34'(r_kd));
                w_mul_b = $signed(KD_SCALE);
            end
            DC_DF: begin
                w_mul_a = $signed(34'(r_kd15));
                w_mul_b = 34'(w_dfe);
            end
            DC_DL: begin
                w_mul_a = $signed(34'(r_kd15));
                w_mul_b = 34'(w_dle);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_dsum   = {1'b0, r_sq} + {1'b0, r_prod[63:0]};
    assign w_dist   = w_dsum[64] ? '1 : w_dsum[63:0];
    assign w_far    = w_dist > r_look2;
    assign w_goal   = w_dist <= GOAL_TOL2;
    assign w_t_zero = (r_tsc == '0);
    assign w_full   = (r_len == LEN_W'(PATH_DEPTH));
    assign w_last   = (LEN_W'(r_idx) == (r_len - LEN_W'(1)));
    assign w_tsum   = {1'b0, r_tsc} + 33'(r_in.elapsed_us);

    assign w_dec_status = (r_in.operation == OP_APPEND && w_full) ? ST_FULL :
                          (r_in.operation == OP_TICK) ? ST_NO_PATH : ST_ACCEPT;

    assign w_dmag      = r_prod[63] ? (64'd0 - r_prod[63:0]) : r_prod[63:0];
    assign w_num       = DIV_NUM_W'(w_dmag) + {30'b0, r_tsc, 1'b0};
    assign w_den       = {r_tsc, 2'b00};
    assign w_div_start = (i_cmd.op == DC_DFGO) || (i_cmd.op == DC_DLGO);

    assign w_fsum = 51'(r_acc) + 51'($signed(r_prod[49:0]));
    assign w_lsum = 51'(r_acc) - 51'($signed(r_prod[49:0]));
    assign w_vlin = 65'(r_pf) + 65'(r_df);
    assign w_vang = 65'(r_pl) + 65'(r_dl);

    lpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= KP_RESET;
            r_kd       <= KD_RESET;
            r_look     <= LOOK_RESET;
            r_lin_lim  <= LIN_RESET;
            r_ang_lim  <= ANG_RESET;
            r_len      <= '0;
            r_prev_fwd <= '0;
            r_prev_lat <= '0;
            r_tsc      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:   r_kp      <= i_cfg_data[15:0];
                    CFG_KD:   r_kd      <= i_cfg_data[15:0];
                    CFG_LOOK: r_look    <= i_cfg_data;
                    CFG_LIN:  r_lin_lim <= i_cfg_data;
                    CFG_ANG:  r_ang_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                DC_DECODE: begin
                    case (r_in.operation)
                        OP_CLEAR:  r_len <= '0;
                        OP_APPEND: if (!w_full) r_len <= r_len + 1'b1;
                        OP_TICK:   r_tsc <= w_tsum[32] ? '1 : w_tsum[31:0];
                        default: ;
                    endcase
                end
                DC_GCHK: if (w_goal) r_len <= '0;
                DC_SUM: begin
                    r_prev_fwd <= r_fwd;
                    r_prev_lat <= r_lat;
                    r_tsc      <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DC_DECODE && r_in.operation == OP_APPEND && !w_full) begin
            r_mem[r_len[IDX_W-1:0]] <= {r_in.waypoint_x, r_in.waypoint_y};
        end
        if (i_cmd.op == DC_READ) begin
            {r_rd_x, r_rd_y} <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            DC_LOAD: r_in <= i_in_word;
            DC_DECODE: r_res <= {w_dec_status, 136'b0};
            DC_LOOK:  r_idx <= IDX_W'(r_len - LEN_W'(1));
            DC_LSAVE: r_look2 <= r_prod[63:0];
            DC_SQY:   r_sq <= r_prod[63:0];
            DC_GSQY:  r_sq <= r_prod[63:0];
            DC_WALK: begin
                if (w_far || w_last) begin
                    r_tgt <= r_idx;
                    r_tx  <= r_rd_x;
                    r_ty  <= r_rd_y;
                end
                if (w_far && r_idx != '0) r_idx <= r_idx - 1'b1;
            end
            DC_GCHK: begin
                r_res.target_index <= 8'(32'(r_tgt));
                r_res.target_x     <= r_tx;
                r_res.target_y     <= r_ty;
                if (w_goal) r_res.status <= ST_GOAL;
                else if (w_t_zero) r_res.status <= ST_ZERO_TIME;
            end
            DC_FWD2:  r_acc <= r_prod[49:0];
            DC_FWD3:  r_fwd <= f_rnd14(w_fsum);
            DC_LAT2:  r_acc <= r_prod[49:0];
            DC_LAT3:  r_lat <= f_rnd14(w_lsum);
            DC_PL:    r_pf <= f_rnd8(r_prod[48:0]);
            DC_KD:    r_pl <= f_rnd8(r_prod[48:0]);
            DC_KDS:   r_kd15 <= r_prod[29:0];
            DC_DFGO:  r_dsign <= r_prod[63];
            DC_DLGO:  r_dsign <= r_prod[63];
            DC_DFGET: begin
                if (w_div_done) begin
                    r_df <= r_dsign ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
                end
            end
            DC_DLGET: begin
                if (w_div_done) begin
                    r_dl <= r_dsign ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
                end
            end
            DC_SUM: begin
                r_res.status           <= ST_COMMAND;
                r_res.linear_velocity  <= f_clamp(w_vlin, r_lin_lim);
                r_res.angular_velocity <= f_clamp(w_vang, r_ang_lim);
            end
            DC_EMIT:  r_out <= r_res;
            default: ;
        endcase
    end

    assign o_sts.op       = r_in.operation;
    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.far      = w_far;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.stop     = w_goal || w_t_zero;
    assign o_sts.div_done = w_div_done;
    assign o_out_word     = r_out;

endmodule

// ----- rtl/lpt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences one word through the datapath and owns the handshakes.
// Depends on lpt_pkg.
module lpt_ctrl import lpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_LOOK, S_LSAVE, S_READ, S_SQX, S_SQY, S_WALK, S_GSQX,
        S_GSQY, S_GCHK, S_FWD1, S_FWD2, S_FWD3, S_LAT1, S_LAT2, S_LAT3, S_PF, S_PL,
        S_KD, S_KDS, S_DF, S_DFGO, S_DFWAIT, S_DL, S_DLGO, S_DLWAIT, S_SUM, S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? DC_LOAD : DC_IDLE;
            S_DECODE: o_cmd.op = DC_DECODE;
            S_LOOK:   o_cmd.op = DC_LOOK;
            S_LSAVE:  o_cmd.op = DC_LSAVE;
            S_READ:   o_cmd.op = DC_READ;
            S_SQX:    o_cmd.op = DC_SQX;
            S_SQY:    o_cmd.op = DC_SQY;
            S_WALK:   o_cmd.op = DC_WALK;
            S_GSQX:   o_cmd.op = DC_GSQX;
            S_GSQY:   o_cmd.op = DC_GSQY;
            S_GCHK:   o_cmd.op = DC_GCHK;
            S_FWD1:   o_cmd.op = DC_FWD1;
            S_FWD2:   o_cmd.op = DC_FWD2;
            S_FWD3:   o_cmd.op = DC_FWD3;
            S_LAT1:   o_cmd.op = DC_LAT1;
            S_LAT2:   o_cmd.op = DC_LAT2;
            S_LAT3:   o_cmd.op = DC_LAT3;
            S_PF:     o_cmd.op = DC_PF;
            S_PL:     o_cmd.op = DC_PL;
            S_KD:     o_cmd.op = DC_KD;
            S_KDS:    o_cmd.op = DC_KDS;
            S_DF:     o_cmd.op = DC_DF;
            S_DFGO:   o_cmd.op = DC_DFGO;
            S_DFWAIT: o_cmd.op = DC_DFGET;
            S_DL:     o_cmd.op = DC_DL;
            S_DLGO:   o_cmd.op = DC_DLGO;
            S_DLWAIT: o_cmd.op = DC_DLGET;
            S_SUM:    o_cmd.op = DC_SUM;
            S_DONE:   o_cmd.op = w_out_free ? DC_EMIT : DC_IDLE;
            default:  o_cmd.op = DC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !(r_state == S_DONE && w_out_free))
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_DECODE;
                        r_in_stall <= 1'b1;
                    end
                end
                S_DECODE: begin
                    if (i_sts.op == OP_TICK && !i_sts.len_zero) r_state <= S_LOOK;
                    else r_state <= S_DONE;
                end
                S_LOOK:  r_state <= S_LSAVE;
                S_LSAVE: r_state <= S_READ;
                S_READ:  r_state <= S_SQX;
                S_SQX:   r_state <= S_SQY;
                S_SQY:   r_state <= S_WALK;
                S_WALK: begin
                    if (i_sts.far && !i_sts.idx_zero) r_state <= S_READ;
                    else r_state <= S_GSQX;
                end
                S_GSQX:  r_state <= S_GSQY;
                S_GSQY:  r_state <= S_GCHK;
                S_GCHK:  r_state <= i_sts.stop ? S_DONE : S_FWD1;
                S_FWD1:  r_state <= S_FWD2;
                S_FWD2:  r_state <= S_FWD3;
                S_FWD3:  r_state <= S_LAT1;
                S_LAT1:  r_state <= S_LAT2;
                S_LAT2:  r_state <= S_LAT3;
                S_LAT3:  r_state <= S_PF;
                S_PF:    r_state <= S_PL;
                S_PL:    r_state <= S_KD;
                S_KD:    r_state <= S_KDS;
                S_KDS:   r_state <= S_DF;
                S_DF:    r_state <= S_DFGO;
                S_DFGO:  r_state <= S_DFWAIT;
                S_DFWAIT: if (i_sts.div_done) r_state <= S_DL;
                S_DL:    r_state <= S_DLGO;
                S_DLGO:  r_state <= S_DLWAIT;
                S_DLWAIT: if (i_sts.div_done) r_state <= S_SUM;
                S_SUM:   r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_in_stall  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/lookahead_pd_path_tracker.sv -----
`timescale 1ns / 1ps
// Lookahead PD path tracker: input word in, one result word out per input word.
// Channels use valid/stall. Clear (op 0) and append (op 1) go from acceptance
// through decode to the result register. A control tick (op 2) walks back from
// the last waypoint, taking a memory read, two squares on the one shared
// multiplier and a compare for each waypoint looked at, then runs the error and
// PD arithmetic, with two waits on the bit-serial divider for the derivative terms.
// A walk looks at up to 256 waypoints; a tick that ends at goal or zero time
// skips the PD arithmetic, and one on an empty path goes from decode to the result.
// One word is worked on at a time; stall stays high from acceptance until the
// result is loaded into the output register. The next word is taken while that
// result waits, so a stalled receiver holds back at most the word behind it.
// Configuration writes (index 0 to 4, higher indexes ignored) are taken in any
// cycle and must come while the block is idle.
// Synchronous reset clears path length, stored errors and elapsed time, loads
// the default gains and limits, and clears the output valid flag. The path memory
// itself is not cleared; only entries below the path length are ever read.
// Depends on lpt_pkg, lpt_ctrl, lpt_dp and lpt_div.
module lookahead_pd_path_tracker import lpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lpt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- rtl/lpt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the path tracker, bound to the top level.
// Depends on lpt_pkg and lookahead_pd_path_tracker.
module lpt_checker import lpt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_word   o_out_word
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is at work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_COMMAND |->
            o_out_word.linear_velocity == '0 && o_out_word.angular_velocity == '0)
        else $error("velocity set without a command");

    a_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_ACCEPT || o_out_word.status == ST_NO_PATH ||
            o_out_word.status == ST_FULL) |->
            o_out_word.target_index == '0 && o_out_word.target_x == '0 &&
            o_out_word.target_y == '0)
        else $error("target set without a tick on a path");

endmodule

bind lookahead_pd_path_tracker lpt_checker u_checker (.*);
